// ----- sv/nrc_pkg.sv -----
// Shared types, constants and helpers for the nearest reference classifier.
// Used by nrc_cell and nearest_reference_classifier; depends on nothing else.
package nrc_pkg;

	localparam int TABLE_DEPTH     = 64;
	localparam int FEATURE_BITS    = 16;
	localparam int SUM_BITS        = 18;
	// three absolute differences of FEATURE_BITS+1 bits each
	localparam int SUM_W           = FEATURE_BITS + 3;
	// wide enough for both the full sum and the reported 18-bit value plus one
	localparam int SUM_X           = (SUM_W > SUM_BITS) ? SUM_W : SUM_BITS + 1;
	localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);

	localparam logic [SUM_BITS-1:0] SUM_NONE        = 18'h3FFFF;
	localparam logic [SUM_BITS-1:0] SUM_SAT         = 18'h3FFFE;
	localparam logic [SUM_BITS-1:0] THRESHOLD_RESET = 18'd7680;

	localparam logic [1:0] OP_CLEAR    = 2'd0;
	localparam logic [1:0] OP_LOAD     = 2'd1;
	localparam logic [1:0] OP_CLASSIFY = 2'd2;

	typedef struct packed {
		logic [1:0]                     operation;
		logic signed [FEATURE_BITS-1:0] feature_a2;
		logic signed [FEATURE_BITS-1:0] feature_a3;
		logic signed [FEATURE_BITS-1:0] feature_a4;
		logic [7:0]                     class_label;
	} in_item_t;

	typedef struct packed {
		logic                matched;
		logic [7:0]          result_label;
		logic [SUM_BITS-1:0] best_distance_sum;
	} out_item_t;

	// query and running best, handed from cell to cell
	typedef struct packed {
		logic                           valid;
		logic signed [FEATURE_BITS-1:0] f0;
		logic signed [FEATURE_BITS-1:0] f1;
		logic signed [FEATURE_BITS-1:0] f2;
		logic                           found;
		logic [SUM_W-1:0]               best;
		logic [7:0]                     label;
	} query_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} cell_ctl_t;

	function automatic logic [FEATURE_BITS:0] abs_diff(
		input logic signed [FEATURE_BITS-1:0] a,
		input logic signed [FEATURE_BITS-1:0] b
	);
		logic [FEATURE_BITS:0] d;
		d = {a[FEATURE_BITS-1], a} - {b[FEATURE_BITS-1], b};
		return d[FEATURE_BITS] ? (~d + 1'b1) : d;
	endfunction

endpackage

// ----- sv/nrc_cell.sv -----
// One table entry of the classifier chain: holds a reference and updates the
// running best of the query passing through. Depends on nrc_pkg.
module nrc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  nrc_pkg::cell_ctl_t ctl,
	input  nrc_pkg::in_item_t wr_item,
	input  nrc_pkg::query_t   prev,
	output nrc_pkg::query_t   next
);

	logic signed [nrc_pkg::FEATURE_BITS-1:0] f0_q, f1_q, f2_q;
	logic [7:0]                              label_q;
	logic                                    used_q;
	nrc_pkg::query_t                         link_q;

	logic [nrc_pkg::SUM_W-1:0] sum;
	logic                      take;

	always_comb begin
		sum = nrc_pkg::SUM_W'(nrc_pkg::abs_diff(prev.f0, f0_q))
		    + nrc_pkg::SUM_W'(nrc_pkg::abs_diff(prev.f1, f1_q))
		    + nrc_pkg::SUM_W'(nrc_pkg::abs_diff(prev.f2, f2_q));
		// strict compare keeps the earliest reference on ties
		take = prev.valid && used_q && (label_q != 8'd0) && (!prev.found || sum < prev.best);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.clr) begin
			used_q <= 1'b0;
		end else if (ctl.wr) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			f0_q    <= wr_item.feature_a2;
			f1_q    <= wr_item.feature_a3;
			f2_q    <= wr_item.feature_a4;
			label_q <= wr_item.class_label;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.valid <= prev.valid;
			link_q.f0    <= prev.f0;
			link_q.f1    <= prev.f1;
			link_q.f2    <= prev.f2;
			link_q.found <= prev.found | take;
			link_q.best  <= take ? sum : prev.best;
			link_q.label <= take ? label_q : prev.label;
		end
	end

	assign next = link_q;

endmodule

// ----- sv/nearest_reference_classifier.sv -----
// Nearest reference classifier: a chain of TABLE_DEPTH cells, one per reference.
// Clear and load items never make the block busy. A classify item walks the
// chain one cell per cycle; the input stalls from its acceptance until its
// result is loaded into the output register. Reset empties the table (entry
// count zero) and sets the threshold to 7680; reference contents stay undefined.
module nearest_reference_classifier (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  nrc_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output nrc_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nrc_pkg::SUM_BITS-1:0]    cfg_data
);

	logic [nrc_pkg::SUM_BITS-1:0] thr_q;
	logic [nrc_pkg::CNT_W-1:0]    count_q;
	logic                         busy_q;
	logic                         hold_v_q;
	nrc_pkg::query_t              hold_q;
	logic                         out_valid_q;
	nrc_pkg::out_item_t           out_item_q;

	logic                         in_acc;
	logic                         do_clear, do_load, do_classify;
	logic                         out_load;
	logic [nrc_pkg::SUM_X-1:0]    best_ext;
	nrc_pkg::query_t              link [0:nrc_pkg::TABLE_DEPTH];

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_acc    = in_valid && !in_stall;

	always_comb begin
		do_clear    = 1'b0;
		do_load     = 1'b0;
		do_classify = 1'b0;
		unique case (in_item.operation)
			nrc_pkg::OP_CLEAR:    do_clear    = in_acc;
			nrc_pkg::OP_LOAD:     do_load     = in_acc;
			nrc_pkg::OP_CLASSIFY: do_classify = in_acc;
			default: ;
		endcase
	end

	always_comb begin
		link[0].valid = do_classify;
		link[0].f0    = in_item.feature_a2;
		link[0].f1    = in_item.feature_a3;
		link[0].f2    = in_item.feature_a4;
		link[0].found = 1'b0;
		link[0].best  = '0;
		link[0].label = 8'd0;
	end

	for (genvar k = 0; k < nrc_pkg::TABLE_DEPTH; k++) begin : g_cell
		nrc_pkg::cell_ctl_t ctl;
		assign ctl.clr = do_clear;
		assign ctl.wr  = do_load && (count_q == nrc_pkg::CNT_W'(k));
		nrc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_item (in_item),
			.prev    (link[k]),
			.next    (link[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= nrc_pkg::THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// loads into a full table are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_clear) begin
			count_q <= '0;
		end else if (do_load && count_q < nrc_pkg::CNT_W'(nrc_pkg::TABLE_DEPTH)) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign out_load = hold_v_q && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_classify) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
			if (link[nrc_pkg::TABLE_DEPTH].valid) begin
				hold_v_q <= 1'b1;
			end else if (out_load) begin
				hold_v_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link[nrc_pkg::TABLE_DEPTH].valid) begin
			hold_q <= link[nrc_pkg::TABLE_DEPTH];
		end
	end

	assign best_ext = nrc_pkg::SUM_X'(hold_q.best);

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!hold_q.found) begin
				out_item_q.matched           <= 1'b0;
				out_item_q.result_label      <= 8'd0;
				out_item_q.best_distance_sum <= nrc_pkg::SUM_NONE;
			end else begin
				out_item_q.matched      <= best_ext < nrc_pkg::SUM_X'(thr_q);
				out_item_q.result_label <= (best_ext < nrc_pkg::SUM_X'(thr_q)) ?
				                           hold_q.label : 8'd0;
				out_item_q.best_distance_sum <=
					(best_ext > nrc_pkg::SUM_X'(nrc_pkg::SUM_SAT)) ?
					nrc_pkg::SUM_SAT : best_ext[nrc_pkg::SUM_BITS-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> busy_q)
		else $error("result held with no classify in flight");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		link[nrc_pkg::TABLE_DEPTH].valid |-> (busy_q && !hold_v_q))
		else $error("chain tail valid outside a scan or over a held result");

	a_classify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		do_classify |=> busy_q)
		else $error("classify accepted but block not busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nrc_pkg::CNT_W'(nrc_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

endmodule
